// ===== rtl/rpc_pkg.sv =====
package rpc_pkg;

    // Configuration register indexes.
    localparam int unsigned CfgIndexWidth = 2;
    localparam logic [CfgIndexWidth-1:0] REG_ACTIVE_CHANNELS    = 2'd0;
    localparam logic [CfgIndexWidth-1:0] REG_RANGE_CHECK_ENABLE = 2'd1;
    localparam logic [CfgIndexWidth-1:0] REG_MIN_WIDTH          = 2'd2;
    localparam logic [CfgIndexWidth-1:0] REG_MAX_WIDTH          = 2'd3;

    // Field widths fixed by the stream formats.
    localparam int unsigned CfgDataWidth  = 16;
    localparam int unsigned CountWidth    = 5;
    localparam int unsigned ChanInWidth   = 8;
    localparam int unsigned TimeWidth     = 32;
    localparam int unsigned PulseWidth    = 16;
    localparam int unsigned EntryChWidth  = 4;
    localparam int unsigned SDataWidth    = 40;
    localparam int unsigned MDataWidth    = 24;

    // Result kinds carried on m_tuser.
    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    // Capture sequencer phases.
    typedef enum logic [1:0] {
        PH_WAIT    = 2'd0,
        PH_LEARN   = 2'd1,
        PH_MEASURE = 2'd2,
        PH_RESYNC  = 2'd3
    } phase_t;

    // Output sequencing states.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_REPLY = 2'd1,
        ST_FRAME = 2'd2
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // capture the incoming edge
        logic frame_start; // clear the frame entry counter
        logic frame_step;  // advance to the next frame entry
        logic show_frame;  // drive a frame entry on the result channel
    } rpc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_pending; // the captured edge completed a frame
        logic frame_last;    // the current frame entry is the final one
    } rpc_status_t;

endpackage

// ===== rtl/rpc_ctrl.sv =====
module rpc_ctrl
    import rpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  rpc_status_t status,
    output rpc_cmd_t    cmd,
    output logic        m_last
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_REPLY;
                end
            end
            ST_REPLY: begin
                if (m_tready) begin
                    state_next = status.frame_pending ? ST_FRAME : ST_IDLE;
                end
            end
            ST_FRAME: begin
                if (m_tready && status.frame_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        s_tready        = 1'b0;
        m_tvalid        = 1'b0;
        m_last          = 1'b0;
        cmd.accept      = 1'b0;
        cmd.frame_start = 1'b0;
        cmd.frame_step  = 1'b0;
        cmd.show_frame  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_REPLY: begin
                m_tvalid        = 1'b1;
                m_last          = !status.frame_pending;
                cmd.frame_start = m_tready && status.frame_pending;
            end
            ST_FRAME: begin
                m_tvalid       = 1'b1;
                m_last         = status.frame_last;
                cmd.show_frame = 1'b1;
                cmd.frame_step = m_tready && !status.frame_last;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/rpc_dpath.sv =====
module rpc_dpath
    import rpc_pkg::*;
#(
    parameter int unsigned MAX_CHANNELS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data,
    input  logic [ChanInWidth-1:0]   in_channel,
    input  logic                     in_rising,
    input  logic [TimeWidth-1:0]     in_time,
    input  rpc_cmd_t                 cmd,
    output rpc_status_t              status,
    output logic                     out_kind,
    output logic [EntryChWidth-1:0]  out_channel,
    output logic [PulseWidth-1:0]    out_width
);

    localparam int unsigned IdxWidth = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // Configuration registers.
    logic [CountWidth-1:0] active_reg;
    logic                  range_en_reg;
    logic [PulseWidth-1:0] min_reg;
    logic [PulseWidth-1:0] max_reg;

    // Capture state.
    phase_t                phase_reg;
    logic [CountWidth-1:0] learned_reg;
    logic [TimeWidth-1:0]  rise_reg    [MAX_CHANNELS];
    logic [PulseWidth-1:0] latched_reg [MAX_CHANNELS];

    // Reply and frame sequencing.
    logic [EntryChWidth-1:0] reply_chan_reg;
    logic [PulseWidth-1:0]   reply_width_reg;
    logic                    frame_reg;
    logic [IdxWidth-1:0]     entry_reg;

    logic [CountWidth-1:0] eff_count;
    logic [IdxWidth-1:0]   idx;
    logic [ChanInWidth:0]  chan_plus1;
    logic                  chan_ok;
    logic                  chan_is_last;
    logic [PulseWidth-1:0] meas_width;
    logic                  width_ok;
    logic                  measuring;

    // Effective channel count, limited to the table depth.
    always_comb begin
        if ({1'b0, active_reg} > (CountWidth+1)'(MAX_CHANNELS)) begin
            eff_count = CountWidth'(MAX_CHANNELS);
        end else begin
            eff_count = active_reg;
        end
    end

    // Edge decode and width measurement.
    assign idx          = in_channel[IdxWidth-1:0];
    assign chan_plus1   = {1'b0, in_channel} + (ChanInWidth+1)'(1);
    assign chan_ok      = in_channel < ChanInWidth'(eff_count);
    assign chan_is_last = chan_plus1 == (ChanInWidth+1)'(learned_reg);
    assign meas_width   = in_time[PulseWidth-1:0] - rise_reg[idx][PulseWidth-1:0];
    assign width_ok     = !range_en_reg || ((meas_width >= min_reg) && (meas_width <= max_reg));
    assign measuring    = chan_ok && !in_rising && (phase_reg == PH_MEASURE);

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= CountWidth'(16);
            range_en_reg <= 1'b0;
            min_reg      <= '0;
            max_reg      <= '1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ACTIVE_CHANNELS:    active_reg   <= cfg_data[CountWidth-1:0];
                REG_RANGE_CHECK_ENABLE: range_en_reg <= cfg_data[0];
                REG_MIN_WIDTH:          min_reg      <= cfg_data;
                REG_MAX_WIDTH:          max_reg      <= cfg_data;
                default:                active_reg   <= active_reg;
            endcase
        end
    end

    // Phase sequencer and channel tables, updated on an input transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_WAIT;
            learned_reg <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                rise_reg[i]    <= '0;
                latched_reg[i] <= '0;
            end
        end else if (cmd.accept && chan_ok) begin
            if (in_rising) begin
                rise_reg[idx] <= in_time;
            end else begin
                unique case (phase_reg)
                    PH_WAIT: begin
                        if (in_channel == '0) begin
                            learned_reg <= CountWidth'(1);
                            phase_reg   <= PH_LEARN;
                        end
                    end
                    PH_LEARN: begin
                        if (chan_plus1 > (ChanInWidth+1)'(learned_reg)) begin
                            learned_reg <= chan_plus1[CountWidth-1:0];
                        end else begin
                            phase_reg <= PH_MEASURE;
                        end
                    end
                    PH_MEASURE: begin
                        if (width_ok) begin
                            latched_reg[idx] <= meas_width;
                        end else begin
                            phase_reg <= PH_RESYNC;
                        end
                    end
                    PH_RESYNC: begin
                        // At the frame's last channel, drop the stale rise time of every active channel.
                        if (chan_is_last) begin
                            for (int i = 0; i < MAX_CHANNELS; i++) begin
                                if ((CountWidth+1)'(i) < {1'b0, eff_count}) begin
                                    rise_reg[i] <= '0;
                                end
                            end
                            phase_reg <= PH_MEASURE;
                        end
                    end
                    default: begin
                        phase_reg <= PH_WAIT;
                    end
                endcase
            end
        end
    end

    // Reply register, loaded on every input transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg <= 1'b0;
        end else if (cmd.accept) begin
            frame_reg <= measuring && width_ok && chan_is_last && (meas_width != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            reply_chan_reg  <= in_channel[EntryChWidth-1:0];
            reply_width_reg <= (measuring && width_ok) ? meas_width : '0;
        end
    end

    // Frame entry counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else if (cmd.frame_start) begin
            entry_reg <= '0;
        end else if (cmd.frame_step) begin
            entry_reg <= entry_reg + IdxWidth'(1);
        end
    end

    assign status.frame_pending = frame_reg;
    assign status.frame_last    = ((CountWidth+1)'(entry_reg) + (CountWidth+1)'(1))
                                  == {1'b0, eff_count};

    // Result selection.
    always_comb begin
        if (cmd.show_frame) begin
            out_kind    = KIND_FRAME;
            out_channel = EntryChWidth'(entry_reg);
            out_width   = latched_reg[entry_reg];
        end else begin
            out_kind    = KIND_REPLY;
            out_channel = reply_chan_reg;
            out_width   = reply_width_reg;
        end
    end

endmodule

// ===== rtl/rc_pwm_pulse_width_capture.sv =====
// RC PWM pulse width capture.
// The input stream carries one timestamped edge per transfer: s_tdata holds
// the channel number and the microsecond timestamp, s_tuser is 1 for a
// rising edge. The result stream returns one reply per edge (m_tuser 0)
// with the accepted width or zero; when the last channel of a frame yields
// a nonzero width, the reply is followed by one entry per active channel
// (m_tuser 1) with the latched widths. m_tlast marks the final result of
// the edge. Registers are written on the cfg port; the user must write them
// only while the block is idle, which the block itself does not enforce.
// An edge is taken while idle and its reply is valid in the next cycle.
// Results leave one per cycle while m_tready is high; no new edge is taken
// until the last result of the previous one is gone.
// A stall on m_tready holds the current result and s_tready stays low.
// Reset clears the phase sequencer, the learned count, all rise times and
// latched widths, and restores the register defaults; no clearing pass is
// needed, so the block takes an edge in the first cycle after reset.
module rc_pwm_pulse_width_capture
    import rpc_pkg::*;
#(
    parameter int unsigned MAX_CHANNELS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // Configuration write port.
    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data,
    // Edge input stream.
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [SDataWidth-1:0]    s_tdata,  // channel_number[7:0], timestamp_us[39:8]
    input  logic                     s_tuser,  // edge_rising[0]
    // Result stream.
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [MDataWidth-1:0]    m_tdata,  // entry_channel[3:0], width_us[19:4], zero[23:20]
    output logic                     m_tuser,  // result_kind[0]
    output logic                     m_tlast
);

    rpc_cmd_t                cmd;
    rpc_status_t             status;
    logic [EntryChWidth-1:0] out_channel;
    logic [PulseWidth-1:0]   out_width;

    rpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd),
        .m_last   (m_tlast)
    );

    rpc_dpath #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_channel  (s_tdata[ChanInWidth-1:0]),
        .in_rising   (s_tuser),
        .in_time     (s_tdata[ChanInWidth+TimeWidth-1:ChanInWidth]),
        .cmd         (cmd),
        .status      (status),
        .out_kind    (m_tuser),
        .out_channel (out_channel),
        .out_width   (out_width)
    );

    // Pack the result fields, lowest field first.
    assign m_tdata = {4'b0000, out_width, out_channel};

endmodule

// ===== rtl/rpc_checker.sv =====
module rpc_checker
    import rpc_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [MDataWidth-1:0] m_tdata,
    input logic                  m_tuser,
    input logic                  m_tlast
);

    // No result is offered in the cycle after reset.
    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Edges are not taken while a result is pending.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // Every edge transfer is answered by a reply in the next cycle.
    a_reply_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (m_tvalid && (m_tuser == KIND_REPLY)))
        else $error("edge transfer not followed by a reply");

    // The run ends after the transfer marked last.
    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
        else $error("results continue after the last of the run");

    // A stalled result holds its contents.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind rc_pwm_pulse_width_capture rpc_checker u_rpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/rc_pwm_pulse_width_capture_tb.sv =====
`timescale 1ns / 1ps

module rc_pwm_pulse_width_capture_tb;
    import rpc_pkg::*;

    localparam int unsigned MAX_CH = 16;
    // Channel count learned at start-up; the frame closes on channel FRAME_CH - 1.
    localparam int unsigned FRAME_CH = 6;
    // The longest quiet stretch in a correct run is the receiver hold-off
    // (HOLD_CYCLES); random stalls sit far below the limit.
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned STALL_LIMIT = 2000;

    // One result transfer, fields in the order kind, channel, width, last.
    typedef struct packed {
        logic        kind;
        logic [3:0]  chan;
        logic [15:0] width;
        logic        is_last;
    } pulse_result_t;

    logic                     aclk;
    logic                     aresetn   = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [CfgDataWidth-1:0]  cfg_data  = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [SDataWidth-1:0]    s_tdata   = '0;  // channel_number[7:0], timestamp_us[39:8]
    logic                     s_tuser   = 1'b0; // edge_rising[0]
    logic                     m_tvalid;
    logic                     m_tready;
    logic [MDataWidth-1:0]    m_tdata;   // entry_channel[3:0], width_us[19:4], zero[23:20]
    logic                     m_tuser;   // result_kind[0]
    logic                     m_tlast;

    rc_pwm_pulse_width_capture #(
        .MAX_CHANNELS(MAX_CH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // Results predicted for accepted edges, oldest first.
    pulse_result_t pending_pulse_results[$];
    int unsigned   mismatch_count = 0;
    int unsigned   stall_cycles   = 0;
    int unsigned   send_idle_pct  = 0;
    int unsigned   recv_idle_pct  = 0;
    int unsigned   hold_request   = 0;

    // Predictor copy of the registers and the capture state.
    logic [4:0]  exp_active;
    logic        exp_check_en;
    logic [15:0] exp_min;
    logic [15:0] exp_max;
    phase_t      exp_phase;
    logic [4:0]  exp_learned;
    logic [31:0] exp_rise [MAX_CH];
    logic [15:0] exp_latched [MAX_CH];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Work out the reply and any frame run that one edge causes.
    function automatic void predict_pulse_results(input logic [7:0] ch, input logic rising,
                                                  input logic [31:0] ts);
        int unsigned   n;
        int unsigned   c;
        logic [15:0]   w;
        logic [15:0]   reply;
        bit            ok;
        bit            frame;
        pulse_result_t r;
        n = (exp_active > MAX_CH) ? MAX_CH : exp_active;
        c = ch;
        reply = '0;
        frame = 1'b0;
        if (c < n) begin
            if (rising) begin
                exp_rise[c] = ts;
            end else begin
                case (exp_phase)
                    PH_WAIT: begin
                        if (c == 0) begin
                            exp_learned = 5'd1;
                            exp_phase = PH_LEARN;
                        end
                    end
                    PH_LEARN: begin
                        if (c + 1 > exp_learned) exp_learned = 5'(c + 1);
                        else exp_phase = PH_MEASURE;
                    end
                    PH_MEASURE: begin
                        w = 16'(ts - exp_rise[c]);
                        ok = !exp_check_en || (w >= exp_min && w <= exp_max);
                        if (ok) begin
                            exp_latched[c] = w;
                            reply = w;
                        end else begin
                            exp_phase = PH_RESYNC;
                        end
                        frame = (c + 1 == exp_learned) && (reply != 0);
                    end
                    default: begin
                        if (c + 1 == exp_learned) begin
                            for (int i = 0; i < n; i++) exp_rise[i] = '0;
                            exp_phase = PH_MEASURE;
                        end
                    end
                endcase
            end
        end
        r = {KIND_REPLY, ch[3:0], reply, !frame};
        pending_pulse_results.push_back(r);
        if (frame) begin
            for (int i = 0; i < n; i++) begin
                r = {KIND_FRAME, 4'(i), exp_latched[i], 1'(i == n - 1)};
                pending_pulse_results.push_back(r);
            end
        end
    endfunction

    // Offer one edge, wait for its transfer and predict its results. Returns in
    // the step of the transfer with s_tvalid still high; the caller decides next.
    task automatic send_edge(input logic [7:0] ch, input logic rising, input logic [31:0] ts);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ts, ch};
        s_tuser  <= rising;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_pulse_results(ch, rising, ts);
    endtask

    // Stop offering edges and wait until every predicted result has arrived.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_pulse_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all four registers on consecutive cycles; only while the block is idle.
    task automatic set_config(input logic [4:0] active, input logic check_en,
                              input logic [15:0] lo, input logic [15:0] hi);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ACTIVE_CHANNELS;
        cfg_data  <= {11'd0, active};
        @(posedge aclk);
        cfg_index <= REG_RANGE_CHECK_ENABLE;
        cfg_data  <= {15'd0, check_en};
        @(posedge aclk);
        cfg_index <= REG_MIN_WIDTH;
        cfg_data  <= lo;
        @(posedge aclk);
        cfg_index <= REG_MAX_WIDTH;
        cfg_data  <= hi;
        @(posedge aclk);
        cfg_we <= 1'b0;
        exp_active   = active;
        exp_check_en = check_en;
        exp_min      = lo;
        exp_max      = hi;
    endtask

    // One well-formed frame: a rise and a fall on every learned channel.
    // A few rises are dropped so the fall reuses the stored rise time.
    task automatic send_frame(input bit allow_reject);
        logic [31:0] t;
        logic [15:0] w;
        t = $urandom;
        for (int c = 0; c < FRAME_CH; c++) begin
            if (allow_reject && $urandom_range(99) < 6) w = 16'($urandom);
            else w = 16'($urandom_range(2000, 1000));
            if ($urandom_range(99) >= 4) send_edge(8'(c), 1'b1, t);
            send_edge(8'(c), 1'b0, t + w);
            t = t + w + $urandom_range(500, 100);
        end
    endtask

    // Ignored channels, the wait for channel 0, learning and the first frame.
    task automatic test_sequencer_startup();
        send_edge(8'd255, 1'b1, 32'hFFFF_FFFF);
        send_edge(8'd16, 1'b0, 32'd0);
        send_edge(8'd3, 1'b0, 32'd100);
        send_edge(8'd0, 1'b0, 32'd200);
        send_edge(8'd5, 1'b0, 32'd300);
        // This fall ends learning and is not measured.
        send_edge(8'd2, 1'b0, 32'd400);
        // Width across the timestamp wrap closes a frame.
        send_edge(8'd5, 1'b1, 32'hFFFF_FFF0);
        send_edge(8'd5, 1'b0, 32'h0000_0010);
        // Fall with no rise since reset measures against zero.
        send_edge(8'd4, 1'b0, 32'hFFFF_FFFF);
        // Zero width on the last channel gives no frame run.
        send_edge(8'd5, 1'b1, 32'h1234_5678);
        send_edge(8'd5, 1'b0, 32'h1234_5678);
        drain_results();
    endtask

    // Range limits, rejection, resync with clearing, and an inverted range.
    task automatic test_range_check();
        set_config(5'd16, 1'b1, 16'd1000, 16'd2000);
        send_edge(8'd5, 1'b1, 32'd1000);
        send_edge(8'd5, 1'b0, 32'd2000);
        send_edge(8'd5, 1'b1, 32'd5000);
        send_edge(8'd5, 1'b0, 32'd7000);
        send_edge(8'd1, 1'b1, 32'd0);
        send_edge(8'd1, 1'b0, 32'd2001);
        send_edge(8'd2, 1'b0, 32'd50);
        send_edge(8'd5, 1'b0, 32'd60);
        // Rise times were cleared, so this fall measures from zero.
        send_edge(8'd5, 1'b0, 32'd1500);
        drain_results();
        set_config(5'd16, 1'b1, 16'hFFFF, 16'h0000);
        send_edge(8'd3, 1'b1, 32'd0);
        send_edge(8'd3, 1'b0, 32'd1500);
        send_edge(8'd5, 1'b0, 32'd0);
        drain_results();
    endtask

    // Zero active channels, a count above the channel limit, and a single channel.
    task automatic test_channel_count();
        set_config(5'd0, 1'b0, 16'd0, 16'hFFFF);
        send_edge(8'd0, 1'b0, 32'd100);
        drain_results();
        set_config(5'd31, 1'b0, 16'd0, 16'hFFFF);
        send_edge(8'd16, 1'b1, 32'd7);
        send_edge(8'd5, 1'b1, 32'd100);
        send_edge(8'd5, 1'b0, 32'd1100);
        drain_results();
        set_config(5'd1, 1'b0, 16'd0, 16'hFFFF);
        send_edge(8'd0, 1'b1, 32'd10);
        send_edge(8'd0, 1'b0, 32'd30);
        send_edge(8'd5, 1'b0, 32'd40);
        drain_results();
    endtask

    // Mostly well-formed frames with random widths, mixed with random edges.
    task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
                                       input logic [4:0] active, input logic check_en,
                                       input logic [15:0] lo, input logic [15:0] hi);
        int unsigned sent;
        logic [7:0]  ch;
        set_config(active, check_en, lo, hi);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        sent = 0;
        while (sent < 55) begin
            if ($urandom_range(99) < 80) begin
                send_frame(check_en);
                sent += 2 * FRAME_CH;
            end else begin
                ch = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
                send_edge(ch, 1'($urandom), $urandom);
                if (ch < active) sent++;
            end
        end
        drain_results();
    endtask

    // Hold the result side off while edges keep coming, so the block stalls its input.
    task automatic test_result_backpressure();
        set_config(5'd16, 1'b0, 16'd0, 16'hFFFF);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = HOLD_CYCLES;
        send_frame(1'b0);
        drain_results();
    endtask

    // Result side: random stalls, or a long hold-off when one is requested.
    initial begin
        int unsigned n;
        m_tready = 1'b0;
        forever begin
            if (hold_request > 0) begin
                n = hold_request;
                hold_request = 0;
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
                @(posedge aclk);
            end
        end
    end

    // Compare every result transfer with the oldest prediction.
    always @(posedge aclk) begin
        pulse_result_t got;
        pulse_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[3:0], m_tdata[19:4], m_tlast};
            if (pending_pulse_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: kind %0d ch %0d width %0d last %0d",
                             got.kind, got.chan, got.width, got.is_last);
            end else begin
                want = pending_pulse_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected kind %0d ch %0d width %0d last %0d",
                                 want.kind, want.chan, want.width, want.is_last);
                        $display("          got kind %0d ch %0d width %0d last %0d",
                                 got.kind, got.chan, got.width, got.is_last);
                    end
                end
            end
        end
    end

    // Watchdog: too many cycles without any transfer ends the run.
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL rc_pwm_pulse_width_capture");
            $finish;
        end
    end

    initial begin
        exp_active   = 5'd16;
        exp_check_en = 1'b0;
        exp_min      = 16'd0;
        exp_max      = 16'hFFFF;
        exp_phase    = PH_WAIT;
        exp_learned  = '0;
        for (int i = 0; i < MAX_CH; i++) begin
            exp_rise[i]    = '0;
            exp_latched[i] = '0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_sequencer_startup();
        test_range_check();
        test_channel_count();
        test_random_traffic(11, 51, 5'd16, 1'b1, 16'd900, 16'd2100);
        test_random_traffic(51, 11, 5'd31, 1'b0, 16'd0, 16'hFFFF);
        test_random_traffic(0, 0, 5'd6, 1'b1, 16'd0, 16'hFFFF);
        test_result_backpressure();

        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS rc_pwm_pulse_width_capture");
        end else begin
            $display("FAIL rc_pwm_pulse_width_capture");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rpc_pkg.sv
rtl/rpc_ctrl.sv
rtl/rpc_dpath.sv
rtl/rc_pwm_pulse_width_capture.sv
rtl/rpc_checker.sv
tb/rc_pwm_pulse_width_capture_tb.sv
